/* hdl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pets_pkg.sv */
package pets_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int ENTRY_W     = $clog2(NUM_ENTRIES);

  localparam logic [3:0] FIELD_REQ_TOTAL = 4'd3;
  localparam logic [3:0] FIELD_MIN       = 4'd6;
  localparam logic [3:0] FIELD_MAX       = 4'd7;
  localparam logic [3:0] FIELD_MEAN      = 4'd8;
  localparam logic [3:0] FIELD_RATE_CONN = 4'd9;
  localparam logic [3:0] FIELD_RATE_REQ  = 4'd10;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [5:0][63:0] cnt;
    logic [63:0]      min_t;
    logic [63:0]      max_t;
    logic [63:0]      mean_t;
    logic [1:0][31:0] sec;
    logic [1:0][63:0] prev;
    logic [1:0][63:0] cur;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_addr;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

/* hdl/pets_mem.sv */
module pets_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pets_pkg::mem_ctl_t        ctl_i,
  input  logic [pets_pkg::ROW_W-1:0] wr_data_i,
  output logic [pets_pkg::ROW_W-1:0] rd_data_o
);

  logic [pets_pkg::ROW_W-1:0]     mem_q [pets_pkg::NUM_ENTRIES];
  logic [pets_pkg::ROW_W-1:0]     rd_q;
  logic [pets_pkg::NUM_ENTRIES-1:0] vld_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[ctl_i.wr_addr] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[ctl_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* hdl/pets_div.sv */
module pets_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [63:0] shifted;

  assign shifted = {rem_q[62:0], quo_q[63]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[63] ^ den_i[63];
      rem_d  = '0;
      quo_d  = num_i[63] ? (64'd0 - num_i) : num_i;
      den_d  = den_i[63] ? (64'd0 - den_i) : den_i;
    end else if (busy_q) begin
      if (shifted >= den_q) begin
        rem_d = shifted - den_q;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

/* hdl/per_entry_traffic_statistics.sv */
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | kind, entry_index, field_select, value,
//         |           |                          | now_seconds
// out     | output    | out_valid_o / out_stall_i| read_value
//
// Reads pass through accept, memory read and the output register.
// Other updates pass through accept, then read, modify and write back.
// A mean update runs the 1-bit-per-cycle signed divider first, then writes back.
// One transaction is in flight at a time; in_stall_o stays high until the state machine is idle.
// Reset clears the per-entry valid bits; an unwritten record reads as zero.
// A read result waits in the output register while out_stall_i is high; a following read
// holds in the output stage and stalls input.
module per_entry_traffic_statistics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [pets_pkg::ENTRY_W-1:0]  entry_index_i,
  input  logic [3:0]                    field_select_i,
  input  logic signed [47:0]            value_i,
  input  logic [31:0]                   now_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   read_value_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic                         kind_q;
  logic [pets_pkg::ENTRY_W-1:0] entry_q;
  logic [3:0]                   field_q;
  logic [63:0]                  value_q;
  logic [31:0]                  now_q;
  pets_pkg::row_t               row_q;
  logic [63:0]                  res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic [63:0]                  out_data_q;

  pets_pkg::mem_ctl_t           mem_ctl;
  logic [pets_pkg::ROW_W-1:0]   rd_bits;
  pets_pkg::row_t               rd_row;
  pets_pkg::row_t               upd_row;
  pets_pkg::row_t               wr_row;
  logic                         upd_ok;

  logic                         div_start;
  logic                         div_done;
  logic [63:0]                  div_quot;
  logic [63:0]                  mean_diff;
  logic [63:0]                  req_total;

  logic                         ridx;
  logic [31:0]                  sec_delta;
  logic                         accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign rd_row     = pets_pkg::row_t'(rd_bits);
  assign ridx       = (field_q == pets_pkg::FIELD_RATE_REQ);
  assign sec_delta  = now_q - rd_row.sec[ridx];
  assign req_total  = rd_row.cnt[pets_pkg::FIELD_REQ_TOTAL[2:0]];
  assign mean_diff  = value_q - rd_row.mean_t;

  pets_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (pets_pkg::ROW_W'(wr_row)),
    .rd_data_o (rd_bits)
  );

  pets_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mean_diff),
    .den_i   (req_total),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    upd_row = rd_row;
    upd_ok  = 1'b1;
    res_d   = '0;
    if (field_q < pets_pkg::FIELD_MIN) begin
      upd_row.cnt[field_q[2:0]] = rd_row.cnt[field_q[2:0]] + value_q;
      res_d = rd_row.cnt[field_q[2:0]];
    end else begin
      case (field_q)
        pets_pkg::FIELD_MIN: begin
          if (value_q != '0 && (rd_row.min_t == '0 || value_q < rd_row.min_t)) begin
            upd_row.min_t = value_q;
          end
          res_d = rd_row.min_t;
        end
        pets_pkg::FIELD_MAX: begin
          if (rd_row.max_t < value_q) begin
            upd_row.max_t = value_q;
          end
          res_d = rd_row.max_t;
        end
        pets_pkg::FIELD_MEAN: begin
          res_d = rd_row.mean_t;
        end
        pets_pkg::FIELD_RATE_CONN, pets_pkg::FIELD_RATE_REQ: begin
          if (rd_row.sec[ridx] == now_q) begin
            upd_row.cur[ridx] = rd_row.cur[ridx] + value_q;
            res_d = rd_row.prev[ridx];
          end else begin
            upd_row.prev[ridx] = (sec_delta == 32'd1) ? rd_row.cur[ridx] : '0;
            upd_row.cur[ridx]  = value_q;
            upd_row.sec[ridx]  = now_q;
            res_d = (sec_delta == 32'd1) ? rd_row.cur[ridx] : '0;
          end
        end
        default: begin
          upd_ok = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && out_stall_i;
    mem_ctl.rd_en    = accept;
    mem_ctl.rd_addr  = entry_index_i;
    mem_ctl.wr_en    = 1'b0;
    mem_ctl.wr_addr  = entry_q;
    wr_row           = upd_row;
    div_start        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (kind_q == pets_pkg::KIND_READ) begin
          state_d = S_OUT;
        end else if (field_q == pets_pkg::FIELD_MEAN) begin
          if (req_total != '0) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          mem_ctl.wr_en = upd_ok;
          state_d       = S_IDLE;
        end
      end
      S_DIV: begin
        wr_row        = row_q;
        wr_row.mean_t = row_q.mean_t + div_quot;
        if (div_done) begin
          mem_ctl.wr_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      entry_q <= entry_index_i;
      field_q <= field_select_i;
      value_q <= {{16{value_i[47]}}, value_i};
      now_q   <= now_seconds_i;
    end
    if (state_q == S_READ) begin
      row_q <= rd_row;
      res_q <= upd_ok ? res_d : '0;
    end
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_data_q;

endmodule

/* hdl/pets_checker.sv */
`include "assert_macros.svh"

module pets_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [63:0]                  read_value_o
);

  `ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "out valid dropped")
  `ASSERT_NEXT(a_out_data_hold, out_valid_o && out_stall_i, $stable(read_value_o), "out data moved")
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no stall after accept")
  `ASSERT_NEXT(a_no_instant_result, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result too early")

endmodule

bind per_entry_traffic_statistics pets_checker u_pets_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o)
);

/* test/tb_per_entry_traffic_statistics.sv */
`timescale 1ns / 100ps

module tb_per_entry_traffic_statistics;

  localparam int DRAIN_CYCLES  = 100;
  localparam int WATCHDOG_MAX  = 20000;
  localparam int RANDOM_ITEMS  = 750;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         kind_i;
  logic [pets_pkg::ENTRY_W-1:0] entry_index_i;
  logic [3:0]                   field_select_i;
  logic signed [47:0]           value_i;
  logic [31:0]                  now_seconds_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [63:0]                  read_value_o;

  per_entry_traffic_statistics DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .field_select_i (field_select_i),
    .value_i        (value_i),
    .now_seconds_i  (now_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o)
  );

  typedef struct {
    logic        kind;
    logic [5:0]  entry;
    logic [3:0]  field;
    logic [47:0] val;
    logic [31:0] now;
    logic        has_exp;
    logic [63:0] exp;
  } stim_row_t;

  logic [63:0] cnt_mdl  [pets_pkg::NUM_ENTRIES*6];
  logic [63:0] min_mdl  [pets_pkg::NUM_ENTRIES];
  logic [63:0] max_mdl  [pets_pkg::NUM_ENTRIES];
  logic [63:0] mean_mdl [pets_pkg::NUM_ENTRIES];
  logic [31:0] sec_mdl  [pets_pkg::NUM_ENTRIES*2];
  logic [63:0] prev_mdl [pets_pkg::NUM_ENTRIES*2];
  logic [63:0] cur_mdl  [pets_pkg::NUM_ENTRIES*2];

  logic [63:0] read_values_due [$];
  stim_row_t   table_rows [$];
  int          errors;
  int          reads_seen;
  int          items_sent;
  int          idle_cycles;
  bit          hold_rx;
  bit          stim_done;

  function automatic logic [63:0] signed_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] qa;
    logic [63:0] na;
    logic [63:0] da;
    na = num[63] ? -num : num;
    da = den[63] ? -den : den;
    qa = na / da;
    return (num[63] ^ den[63]) ? -qa : qa;
  endfunction

  function automatic void apply_item(logic kind, logic [5:0] e, logic [3:0] f,
                                     logic [47:0] val, logic [31:0] now);
    logic [63:0] v;
    logic [63:0] n;
    logic [63:0] rv;
    int          r;
    v = {{16{val[47]}}, val};
    if (kind == pets_pkg::KIND_READ) begin
      rv = '0;
      if (f < pets_pkg::FIELD_MIN) rv = cnt_mdl[e*6+f];
      else if (f == pets_pkg::FIELD_MIN) rv = min_mdl[e];
      else if (f == pets_pkg::FIELD_MAX) rv = max_mdl[e];
      else if (f == pets_pkg::FIELD_MEAN) rv = mean_mdl[e];
      else if (f <= pets_pkg::FIELD_RATE_REQ) begin
        r = e*2 + (f - pets_pkg::FIELD_RATE_CONN);
        if (now == sec_mdl[r]) rv = prev_mdl[r];
        else if (now - sec_mdl[r] == 32'd1) rv = cur_mdl[r];
      end
      read_values_due.push_back(rv);
    end else if (f < pets_pkg::FIELD_MIN) begin
      cnt_mdl[e*6+f] += v;
    end else if (f == pets_pkg::FIELD_MIN) begin
      if (v != 0 && (min_mdl[e] == 0 || v < min_mdl[e])) min_mdl[e] = v;
    end else if (f == pets_pkg::FIELD_MAX) begin
      if (max_mdl[e] < v) max_mdl[e] = v;
    end else if (f == pets_pkg::FIELD_MEAN) begin
      n = cnt_mdl[e*6+pets_pkg::FIELD_REQ_TOTAL];
      if (n != 0) mean_mdl[e] += signed_quotient(v - mean_mdl[e], n);
    end else if (f <= pets_pkg::FIELD_RATE_REQ) begin
      r = e*2 + (f - pets_pkg::FIELD_RATE_CONN);
      if (sec_mdl[r] == now) cur_mdl[r] += v;
      else begin
        prev_mdl[r] = (now - sec_mdl[r] == 32'd1) ? cur_mdl[r] : 64'd0;
        cur_mdl[r] = v;
        sec_mdl[r] = now;
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  task automatic send_item(logic kind, logic [5:0] e, logic [3:0] f,
                           logic [47:0] val, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    entry_index_i  <= e;
    field_select_i <= f;
    value_i        <= val;
    now_seconds_i  <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_item(kind, e, f, val, now);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (read_values_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return 48'({$urandom, $urandom});
      3: return 48'(-int'($urandom_range(1, 100)));
      default: return 48'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic stim_row_t make_row(logic kind, logic [5:0] e, logic [3:0] f,
                                         logic [47:0] val, logic [31:0] now,
                                         logic has_exp, logic [63:0] exp);
    stim_row_t row;
    row.kind = kind; row.entry = e; row.field = f; row.val = val; row.now = now;
    row.has_exp = has_exp; row.exp = exp;
    return row;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t watchdog expired", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reads_seen <= reads_seen + 1;
      if (read_values_due.size() == 0) begin
        $display("%0t unexpected read: expected none actual %h", $time, read_value_o);
        errors++;
      end else begin
        if (read_value_o !== read_values_due[0]) begin
          $display("%0t read_value: expected %h actual %h", $time,
                   read_values_due[0], read_value_o);
          errors++;
        end
        void'(read_values_due.pop_front());
      end
    end
  end

  initial begin
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_rx = 1'b0;
        @(posedge clk_i);
      end else if (stim_done) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [5:0]  e;
    logic [3:0]  f;
    logic [31:0] base;
    stim_row_t   row;
    in_valid_i = 1'b0; kind_i = 1'b0; entry_index_i = '0; field_select_i = '0;
    value_i = '0; now_seconds_i = '0;
    errors = 0; reads_seen = 0; items_sent = 0; hold_rx = 0; stim_done = 0;
    for (int i = 0; i < pets_pkg::NUM_ENTRIES*6; i++) cnt_mdl[i] = '0;
    for (int i = 0; i < pets_pkg::NUM_ENTRIES; i++) begin
      min_mdl[i] = '0; max_mdl[i] = '0; mean_mdl[i] = '0;
    end
    for (int i = 0; i < pets_pkg::NUM_ENTRIES*2; i++) begin
      sec_mdl[i] = '0; prev_mdl[i] = '0; cur_mdl[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd0, 4'd0, '0, '0, 1'b1, 64'd0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd63, pets_pkg::FIELD_MIN, '0, '0,
                                  1'b1, 64'd0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd1, 4'd0, 48'h7FFF_FFFF_FFFF, '0,
                                  1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd1, 4'd0, '0, '0, 1'b1,
                                  64'h7FFF_FFFF_FFFF));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd1, 4'd5, 48'h8000_0000_0000, '0,
                                  1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd1, 4'd5, '0, '0, 1'b1,
                                  64'hFFFF_8000_0000_0000));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd2, pets_pkg::FIELD_MIN, 48'd0, '0,
                                  1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd2, pets_pkg::FIELD_MIN, '0, '0,
                                  1'b1, 64'd0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd2, pets_pkg::FIELD_MIN,
                                  48'hFFFF_FFFF_FFFF, '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd2, pets_pkg::FIELD_MIN, 48'd5, '0,
                                  1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd2, pets_pkg::FIELD_MIN, '0, '0,
                                  1'b1, 64'd5));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd2, pets_pkg::FIELD_MAX,
                                  48'hFFFF_FFFF_FFFF, '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd2, pets_pkg::FIELD_MAX, '0, '0,
                                  1'b1, '1));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd3, pets_pkg::FIELD_MEAN, 48'd100,
                                  '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd3, pets_pkg::FIELD_MEAN, '0, '0,
                                  1'b1, 64'd0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd3, pets_pkg::FIELD_REQ_TOTAL,
                                  48'hFFFF_FFFF_FFFD, '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd3, pets_pkg::FIELD_MEAN, 48'd100,
                                  '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd3, pets_pkg::FIELD_MEAN, '0, '0,
                                  1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd4, pets_pkg::FIELD_RATE_CONN,
                                  48'd7, 32'hFFFF_FFFF, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd4, pets_pkg::FIELD_RATE_CONN,
                                  48'd9, 32'd0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd4, pets_pkg::FIELD_RATE_CONN, '0,
                                  32'd0, 1'b1, 64'd7));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd4, pets_pkg::FIELD_RATE_CONN, '0,
                                  32'd1, 1'b1, 64'd9));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd4, pets_pkg::FIELD_RATE_REQ, '0,
                                  32'd2, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_UPDATE, 6'd5, 4'd15, 48'd1, '0, 1'b0, '0));
    table_rows.push_back(make_row(pets_pkg::KIND_READ, 6'd5, 4'd11, '0, '0, 1'b1, 64'd0));

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.has_exp) begin
        send_item(row.kind, row.entry, row.field, row.val, row.now);
        if (read_values_due[$] !== row.exp) begin
          $display("%0t table row %0d: expected %h actual %h", $time, i, row.exp,
                   read_values_due[$]);
          errors++;
        end
      end else begin
        send_item(row.kind, row.entry, row.field, row.val, row.now);
      end
    end

    wait_drained();
    base = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) hold_rx = 1'b1;
      if (i == 400) wait_drained();
      e = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
      f = ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
      if ($urandom_range(0, 2) == 0) base += $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) f = pets_pkg::FIELD_REQ_TOTAL;
      send_item(1'($urandom_range(0, 2) == 0), e, f, rand_value(),
                ($urandom_range(0, 15) == 0) ? $urandom : base);
    end
    stim_done = 1'b1;
    wait_drained();
    $display("%0d items sent, %0d reads checked over all fields, rate wrap and idle gaps",
             items_sent, reads_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
